// ===== src/point_in_polygon_test_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-polygon test
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_TOP_MACROS_SVH
`define POINT_IN_POLYGON_TEST_TOP_MACROS_SVH

// Same-cycle implication.
`define PIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Sizes, request codes and the query token that walks the cell chain.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	// Query token handed from cell to cell.
	typedef struct packed {
		logic                          valid;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic signed [COORD_BITS-1:0] prev_x;
		logic signed [COORD_BITS-1:0] prev_y;
		logic                          prev_ok;
		logic                          parity;
	} pip_tok_t;

	// Per-cell control from the top level.
	typedef struct packed {
		logic adv;
		logic wr_en;
		logic own_ok;
	} pip_cell_ctl_t;

endpackage

// ===== src/pip_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying clear, append and query requests.
// ----------------------------------------------------------------------------
interface pip_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       req_type;
	logic signed [pip_pkg::COORD_BITS-1:0] coord_x;
	logic signed [pip_pkg::COORD_BITS-1:0] coord_y;

	modport source (output valid, output req_type, output coord_x, output coord_y,
		input ready);
	modport sink (input valid, input req_type, input coord_x, input coord_y,
		output ready);
endinterface

// ===== src/pip_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one inside flag per query.
// ----------------------------------------------------------------------------
interface pip_res_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, output inside_res, input ready);
	modport sink (input valid, input inside_res, output ready);
endinterface

// ===== src/pip_cell.sv =====
// ----------------------------------------------------------------------------
// Polygon vertex cell
// Holds one vertex and tests the edge from the previous vertex against the
// query token passing through, toggling the crossing parity.
// ----------------------------------------------------------------------------
module pip_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pip_pkg::pip_cell_ctl_t                ctl,
	input  logic signed [pip_pkg::COORD_BITS-1:0] wr_x,
	input  logic signed [pip_pkg::COORD_BITS-1:0] wr_y,
	input  pip_pkg::pip_tok_t                     tok_in,
	output pip_pkg::pip_tok_t                     tok_out
);
	localparam int CB = pip_pkg::COORD_BITS;

	logic signed [CB-1:0]                 vx_q;
	logic signed [CB-1:0]                 vy_q;
	logic                                 tok_valid_q;
	pip_pkg::pip_tok_t                    tok_q;
	logic signed [pip_pkg::DIFF_W-1:0]    dx_p;
	logic signed [pip_pkg::DIFF_W-1:0]    dx_e;
	logic signed [pip_pkg::DIFF_W-1:0]    dy_e;
	logic signed [pip_pkg::DIFF_W-1:0]    dy_p;
	logic signed [pip_pkg::PROD_W-1:0]    lhs;
	logic signed [pip_pkg::PROD_W-1:0]    rhs;
	logic                                 straddle;
	logic                                 left_of;
	logic                                 toggle;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			vx_q <= wr_x;
			vy_q <= wr_y;
		end
	end

	// Edge runs from the previous vertex (i) to this one (j).
	always_comb begin
		straddle = (tok_in.prev_y > tok_in.py) != (vy_q > tok_in.py);
		dx_p = {tok_in.px[CB-1], tok_in.px} - {tok_in.prev_x[CB-1], tok_in.prev_x};
		dx_e = {vx_q[CB-1], vx_q} - {tok_in.prev_x[CB-1], tok_in.prev_x};
		dy_e = {vy_q[CB-1], vy_q} - {tok_in.prev_y[CB-1], tok_in.prev_y};
		dy_p = {tok_in.py[CB-1], tok_in.py} - {tok_in.prev_y[CB-1], tok_in.prev_y};
		lhs = pip_pkg::PROD_W'(dx_p) * pip_pkg::PROD_W'(dy_e);
		rhs = pip_pkg::PROD_W'(dx_e) * pip_pkg::PROD_W'(dy_p);
		// Flip the sense of the crossing compare for a downward edge.
		left_of = dy_e[pip_pkg::DIFF_W-1] ? (rhs < lhs) : (lhs < rhs);
		toggle = tok_in.prev_ok && ctl.own_ok && straddle && left_of;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (ctl.adv) begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			tok_q.valid   <= tok_in.valid;
			tok_q.px      <= tok_in.px;
			tok_q.py      <= tok_in.py;
			tok_q.prev_x  <= vx_q;
			tok_q.prev_y  <= vy_q;
			tok_q.prev_ok <= ctl.own_ok;
			tok_q.parity  <= tok_in.parity ^ toggle;
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end
endmodule

// ===== src/point_in_polygon_test_top.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test top level
// Polyline store as a row of vertex cells with a crossing-number query.
// ----------------------------------------------------------------------------
// Clear and append requests are written into registers at the edge that
// accepts them. A query enters the first vertex cell and moves one cell per
// cycle, while the chain is not stalled, down a chain of MAX_VERTICES
// cells, each cell testing the edge that ends at its own vertex, so a query
// passes through every cell whatever the vertex count, and the next request
// is taken once the query result leaves the chain for the output register.
// One query is in the chain at a time and no new request is taken until
// the query leaves it.
// The chain stalls only if its result finds the output register still full.
module point_in_polygon_test_top (
	input  logic clk,
	input  logic arst_n,
	pip_req_if.sink   req,
	pip_res_if.source res
);
	`include "point_in_polygon_test_top_macros.svh"

	localparam int NV = pip_pkg::MAX_VERTICES;

	logic                       busy_q;
	logic [pip_pkg::CNT_W-1:0]  count_q;
	logic                       out_valid_q;
	logic                       inside_q;
	logic                       req_acc;
	logic                       app_acc;
	logic                       clr_acc;
	logic                       qry_acc;
	logic                       adv;
	pip_pkg::pip_tok_t          tok [NV+1];
	logic [NV-1:0]              tok_valid_vec;
	pip_pkg::pip_cell_ctl_t     cell_ctl [NV];

	assign req.ready = !busy_q;
	assign req_acc   = req.valid && req.ready;

	always_comb begin
		clr_acc = 1'b0;
		app_acc = 1'b0;
		qry_acc = 1'b0;
		if (req_acc) begin
			unique case (req.req_type)
				pip_pkg::REQ_CLEAR:  clr_acc = 1'b1;
				pip_pkg::REQ_APPEND: app_acc = 1'b1;
				pip_pkg::REQ_QUERY:  qry_acc = 1'b1;
				default: ;
			endcase
		end
	end

	// Hold the chain while the finished token cannot enter a full output register.
	assign adv = !(tok[NV].valid && out_valid_q && !res.ready);

	always_comb begin
		tok[0]         = '0;
		tok[0].valid   = qry_acc;
		tok[0].px      = req.coord_x;
		tok[0].py      = req.coord_y;
		tok[0].prev_ok = 1'b0;
		tok[0].parity  = 1'b0;
	end

	for (genvar k = 0; k < NV; k++) begin : g_cell
		always_comb begin
			cell_ctl[k].adv    = adv;
			cell_ctl[k].wr_en  = app_acc && (count_q == pip_pkg::CNT_W'(k));
			cell_ctl[k].own_ok = pip_pkg::CNT_W'(k) < count_q;
		end
		assign tok_valid_vec[k] = tok[k+1].valid;

		pip_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl[k]),
			.wr_x    (req.coord_x),
			.wr_y    (req.coord_y),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr_acc) begin
			count_q <= '0;
		end else if (app_acc && (count_q < pip_pkg::CNT_W'(NV))) begin
			count_q <= count_q + pip_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (qry_acc) begin
			busy_q <= 1'b1;
		end else if (tok[NV].valid && adv) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tok[NV].valid && adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[NV].valid && adv) begin
			inside_q <= tok[NV].parity;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.inside_res = inside_q;

	`PIP_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= pip_pkg::CNT_W'(NV), "vertex count above capacity")
	`PIP_ASSERT_NOW(a_one_token, clk, arst_n, 1'b1, $onehot0(tok_valid_vec), "more than one query in the chain")
	`PIP_ASSERT_NOW(a_busy_token, clk, arst_n, |tok_valid_vec, busy_q, "query in chain while request port open")
	`PIP_ASSERT_NEXT(a_append_inc, clk, arst_n, app_acc && (count_q < pip_pkg::CNT_W'(NV)), count_q == $past(count_q) + pip_pkg::CNT_W'(1), "append did not advance the vertex count")
endmodule

// ===== verif/point_in_polygon_test_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-in-polygon test top level testbench
// Feeds clear, append and query requests under random valid and ready
// gaps. A crossing-number predictor tracks the stored polyline and the
// expected inside flag of every query, and each returned flag is compared.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top_tb;
	import pip_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int QUIET_TAIL   = 60;
	localparam int RANDOM_ITEMS = 420;
	localparam int STUCK_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = MAX_VERTICES + 8;

	typedef struct {
		logic [1:0]                   kind;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		bit                           typed;
		bit                           typed_inside;
	} req_row_t;

	// Directed rows; a typed flag is checked as given, others by the predictor.
	localparam int DIRECTED_ROWS = 23;
	req_row_t directed_rows [DIRECTED_ROWS] = '{
		'{REQ_QUERY,       0,       0, 1'b1, 1'b0},
		'{REQ_APPEND,      5,      -5, 1'b0, 1'b0},
		'{REQ_QUERY,       0,       0, 1'b1, 1'b0},
		'{REQ_UNUSED,     -1,      -1, 1'b0, 1'b0},
		'{REQ_CLEAR,       0,       0, 1'b0, 1'b0},
		'{REQ_APPEND, -32768,  -32768, 1'b0, 1'b0},
		'{REQ_APPEND,  32767,   32767, 1'b0, 1'b0},
		'{REQ_QUERY,  -32768,       0, 1'b1, 1'b1},
		'{REQ_QUERY,   32767,       0, 1'b1, 1'b0},
		'{REQ_QUERY,       0,   32767, 1'b1, 1'b0},
		'{REQ_QUERY,  -32768,  -32768, 1'b0, 1'b0},
		'{REQ_APPEND, -32768,   32767, 1'b0, 1'b0},
		'{REQ_APPEND,  32767,  -32768, 1'b0, 1'b0},
		'{REQ_QUERY,       0,       0, 1'b0, 1'b0},
		'{REQ_QUERY,    -100,      10, 1'b0, 1'b0},
		'{REQ_CLEAR,       0,       0, 1'b0, 1'b0},
		'{REQ_QUERY,       0,       0, 1'b1, 1'b0},
		'{REQ_APPEND,      0,       0, 1'b0, 1'b0},
		'{REQ_APPEND,     10,       0, 1'b0, 1'b0},
		'{REQ_APPEND,      0,      10, 1'b0, 1'b0},
		'{REQ_QUERY,       1,       1, 1'b0, 1'b0},
		'{REQ_QUERY,      -1,       5, 1'b0, 1'b0},
		'{REQ_QUERY,      11,       5, 1'b0, 1'b0}
	};

	logic clk;
	logic arst_n;

	pip_req_if req ();
	pip_res_if res ();

	point_in_polygon_test_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	req_row_t req_plan [$];
	int       plan_idx;
	int       src_gap;
	int       src_gap_pct;
	int       sink_stall;
	int       sink_stall_pct;
	int       stuck_cycles;
	int       error_count;

	// Predictor state: the polyline as the block should hold it.
	logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
	int                           poly_len;
	logic                         pending_inside [$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic req_row_t make_row(logic [1:0] kind, logic signed [COORD_BITS-1:0] x,
		logic signed [COORD_BITS-1:0] y);
		req_row_t r;
		r.kind         = kind;
		r.x            = x;
		r.y            = y;
		r.typed        = 1'b0;
		r.typed_inside = 1'b0;
		return r;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] pick_coord(int spread);
		logic signed [COORD_BITS-1:0] v;
		case (spread)
			0: v = COORD_BITS'($urandom_range(0, 65535));
			1: v = COORD_BITS'($urandom_range(0, 40) - 20);
			default: begin
				case ($urandom_range(0, 4))
					0: v = -32768;
					1: v = 32767;
					2: v = -1;
					3: v = 1;
					default: v = 0;
				endcase
			end
		endcase
		return v;
	endfunction

	// Crossing-number parity of the point against the open polyline.
	function automatic logic crossing_parity(logic signed [COORD_BITS-1:0] px,
		logic signed [COORD_BITS-1:0] py);
		logic   flag;
		longint xi, yi, xj, yj, dy, lhs, rhs;
		flag = 1'b0;
		for (int i = 0; i + 1 < poly_len; i++) begin
			xi = poly_x[i];
			yi = poly_y[i];
			xj = poly_x[i+1];
			yj = poly_y[i+1];
			if ((yi > py) != (yj > py)) begin
				dy  = yj - yi;
				lhs = (px - xi) * dy;
				rhs = (xj - xi) * (py - yi);
				// flip the sense of the comparison for a downward edge
				if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs))
					flag = ~flag;
			end
		end
		return flag;
	endfunction

	function automatic void track_request(req_row_t r);
		case (r.kind)
			REQ_CLEAR: poly_len = 0;
			REQ_APPEND: begin
				// drop the append once the list is full
				if (poly_len < MAX_VERTICES) begin
					poly_x[poly_len] = r.x;
					poly_y[poly_len] = r.y;
					poly_len++;
				end
			end
			REQ_QUERY: pending_inside.insert(pending_inside.size(), r.typed ? r.typed_inside
				: crossing_parity(r.x, r.y));
			default: ;
		endcase
	endfunction

	function automatic void check_inside(logic got);
		logic want;
		if (pending_inside.size() == 0) begin
			$display("%0t: inside_res expected none, actual %0b", $time, got);
			error_count++;
		end else begin
			want = pending_inside.pop_front();
			if (got !== want) begin
				$display("%0t: inside_res expected %0b, actual %0b", $time, want, got);
				error_count++;
			end
		end
	endfunction

	function automatic void build_plan();
		req_row_t                     r;
		logic signed [COORD_BITS-1:0] seq_y [$];
		int                           counted;
		int                           n_vert;
		int                           n_query;
		int                           spread;
		foreach (directed_rows[i])
			req_plan.insert(req_plan.size(), directed_rows[i]);
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: any code, full-range coordinates
				r = make_row(2'($urandom_range(0, 3)), pick_coord(0), pick_coord(0));
				req_plan.insert(req_plan.size(), r);
				if (r.kind != REQ_UNUSED)
					counted++;
			end else begin
				seq_y.delete();
				spread = $urandom_range(0, 5) == 0 ? 0 : ($urandom_range(0, 5) == 0 ? 2 : 1);
				if ($urandom_range(0, 4) != 0) begin
					req_plan.insert(req_plan.size(),
						make_row(REQ_CLEAR, pick_coord(0), pick_coord(0)));
					counted++;
				end
				n_vert = $urandom_range(0, 9) == 0 ? $urandom_range(40, 70)
					: $urandom_range(2, 10);
				for (int v = 0; v < n_vert; v++) begin
					r = make_row(REQ_APPEND, pick_coord(spread), pick_coord(spread));
					seq_y.insert(seq_y.size(), r.y);
					req_plan.insert(req_plan.size(), r);
					counted++;
				end
				n_query = $urandom_range(1, 5);
				for (int q = 0; q < n_query; q++) begin
					r = make_row(REQ_QUERY, pick_coord(spread), pick_coord(spread));
					// land on a vertex height now and then
					if ($urandom_range(0, 3) == 0)
						r.y = seq_y[$urandom_range(0, seq_y.size() - 1)];
					else if ($urandom_range(0, 7) == 0)
						r.x = pick_coord(0);
					req_plan.insert(req_plan.size(), r);
					counted++;
				end
			end
		end
	endfunction

	// Request side: hold the transaction until taken, gaps in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid    <= 1'b0;
			req.req_type <= REQ_CLEAR;
			req.coord_x  <= '0;
			req.coord_y  <= '0;
			plan_idx     = 0;
			src_gap      = 0;
			src_gap_pct  = 20;
		end else begin
			if (req.valid && req.ready) begin
				track_request(req_plan[plan_idx]);
				plan_idx++;
				if (plan_idx % 40 == 0)
					src_gap_pct = $urandom_range(0, 2) * 15;
			end
			if (!(req.valid && !req.ready)) begin
				if (plan_idx >= req_plan.size()) begin
					req.valid <= 1'b0;
				end else if (src_gap > 0) begin
					src_gap--;
					req.valid <= 1'b0;
				end else if (plan_idx + QUIET_TAIL < req_plan.size()
					&& $urandom_range(0, 99) < src_gap_pct) begin
					src_gap = $urandom_range(1, 5) - 1;
					req.valid <= 1'b0;
				end else begin
					req.valid    <= 1'b1;
					req.req_type <= req_plan[plan_idx].kind;
					req.coord_x  <= req_plan[plan_idx].x;
					req.coord_y  <= req_plan[plan_idx].y;
				end
			end
		end
	end

	// Result side: check each transaction, stall in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready      <= 1'b0;
			sink_stall     = 0;
			sink_stall_pct = 20;
		end else begin
			if (res.valid && res.ready) begin
				check_inside(res.inside_res);
				if ($urandom_range(0, 7) == 0)
					sink_stall_pct = $urandom_range(0, 2) * 20;
			end
			if (sink_stall > 0) begin
				sink_stall--;
				res.ready <= 1'b0;
			end else if (plan_idx + QUIET_TAIL < req_plan.size()
				&& $urandom_range(0, 99) < sink_stall_pct) begin
				sink_stall = $urandom_range(1, 5) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		stuck_cycles = 0;
		while (stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("point_in_polygon_test_top: mismatch");
		$finish;
	end

	initial begin
		error_count = 0;
		poly_len    = 0;
		build_plan();
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (plan_idx < req_plan.size())
			@(posedge clk);
		while (pending_inside.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("point_in_polygon_test_top: match");
		else
			$display("point_in_polygon_test_top: mismatch");
		$finish;
	end

endmodule
